// File: rtl/core/i2c_target_register_file_port_top_defines.svh
// assertion macros shared by the i2c target register file port rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef I2C_TARGET_REGISTER_FILE_PORT_TOP_DEFINES_SVH
`define I2C_TARGET_REGISTER_FILE_PORT_TOP_DEFINES_SVH

// same-cycle implication under an active-low reset
`define TRF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("trf assertion failed");

// next-cycle implication under an active-low reset
`define TRF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("trf assertion failed");

`endif

// File: rtl/core/i2c_trf_pkg.sv
// types, constants and helper functions of the i2c target register file port
// no dependencies; imported by the ctrl, datapath and top modules of the block
package i2c_trf_pkg;

  localparam int unsigned MaxEndpoints  = 8;
  localparam int unsigned EndpointBytes = 256;
  localparam int unsigned StoreDepth    = MaxEndpoints * EndpointBytes;
  localparam int unsigned AddrW         = $clog2(StoreDepth);
  localparam int unsigned EpW           = 3;
  localparam int unsigned IdxW          = 8;
  localparam int unsigned SizeW         = $clog2(EndpointBytes) + 1;
  localparam int unsigned SigShift      = 5;
  localparam logic [7:0]  EpMask        = 8'h0F;
  localparam logic [7:0]  SigMask       = 8'hE0;

  typedef enum logic [2:0] {
    FN_ADDR  = 3'd0,
    FN_STOP  = 3'd1,
    FN_WRITE = 3'd2,
    FN_READ  = 3'd3,
    FN_TICK  = 3'd4,
    FN_LOCAL = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_SELECT = 3'd1,
    M_SETIDX = 3'd2,
    M_RW     = 3'd3,
    M_SIGNAL = 3'd4,
    M_ERROR  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    R_NONE = 2'd0,
    R_ACK  = 2'd1,
    R_NACK = 2'd2,
    R_DONE = 2'd3
  } resp_e;

  typedef enum logic [1:0] {
    CFG_EP_COUNT = 2'd0,
    CFG_EP_SIZES = 2'd1,
    CFG_WR_MASK  = 2'd2,
    CFG_SIG_EN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CTRL_CLEAR  = 2'd0,
    CTRL_IDLE   = 2'd1,
    CTRL_LOOKUP = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [AddrW-1:0] store_addr(input logic [EpW-1:0] ep,
                                                  input logic [IdxW-1:0] idx);
    logic [AddrW-1:0] base;
    base = AddrW'(AddrW'(ep) * AddrW'(EndpointBytes));
    return AddrW'(base + AddrW'(idx));
  endfunction

  function automatic logic [SizeW-1:0] ep_size(input logic [63:0] sizes,
                                               input logic [EpW-1:0] ep);
    logic [7:0] raw;
    raw = sizes[8*ep +: 8];
    if (SizeW'(raw) > SizeW'(EndpointBytes)) begin
      return SizeW'(EndpointBytes);
    end
    return SizeW'(raw);
  endfunction

endpackage

// File: rtl/core/i2c_trf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module i2c_trf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/i2c_trf_ctrl.sv
// controller state machine: store clearing pass, item accept and commit
// depends on i2c_trf_pkg
module i2c_trf_ctrl
  import i2c_trf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      in_ready_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_CLEAR:  if (stat_i.clr_last) state_d = CTRL_IDLE;
      CTRL_IDLE:   if (in_valid_i) state_d = CTRL_LOOKUP;
      CTRL_LOOKUP: if (stat_i.out_free) state_d = CTRL_IDLE;
      default:     state_d = CTRL_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CTRL_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      CTRL_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      CTRL_LOOKUP: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/i2c_trf_dp.sv
// datapath: configuration, bus state, register store and result register
// depends on i2c_trf_pkg and i2c_trf_ram
module i2c_trf_dp
  import i2c_trf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       cmd_i,
  output dp_stat_t        stat_o,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [63:0]     cfg_data_i,
  input  logic [2:0]      func_i,
  input  logic [7:0]      data_in_i,
  input  logic [EpW-1:0]  local_endpoint_i,
  input  logic [IdxW-1:0] local_index_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      response_o,
  output logic [7:0]      read_data_o,
  output logic            signal_valid_o,
  output logic [EpW-1:0]  signal_endpoint_o,
  output logic [2:0]      signal_code_o
);

  logic [3:0]  cfg_ep_count_q;
  logic [63:0] cfg_ep_sizes_q;
  logic [7:0]  cfg_wr_mask_q;
  logic        cfg_sig_en_q;

  logic [2:0]      func_q;
  logic [7:0]      data_q;
  logic [EpW-1:0]  lep_q;
  logic [IdxW-1:0] lidx_q;

  mode_e           mode_q, mode_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [EpW-1:0]  sel_q, sel_d;
  logic            flag_q, flag_d;

  logic [AddrW-1:0] clr_cnt_q;

  logic            out_valid_q;
  resp_e           resp_q, resp_d;
  logic [7:0]      rdata_q, rdata_d;
  logic            sv_q, sv_d;
  logic [EpW-1:0]  sep_q, sep_d;
  logic [2:0]      scode_q, scode_d;

  logic             st_we;
  logic [AddrW-1:0] st_waddr;
  logic [7:0]       st_wdata;
  logic [7:0]       st_rdata;
  logic             item_we;
  logic [AddrW-1:0] item_waddr;

  logic [3:0] sel_ep;
  logic       sel_ok;
  logic       idx_ok;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ep_count_q <= 4'd1;
      cfg_ep_sizes_q <= 64'd8;
      cfg_wr_mask_q  <= 8'd0;
      cfg_sig_en_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EP_COUNT: cfg_ep_count_q <= cfg_data_i[3:0];
        CFG_EP_SIZES: cfg_ep_sizes_q <= cfg_data_i;
        CFG_WR_MASK:  cfg_wr_mask_q  <= cfg_data_i[7:0];
        CFG_SIG_EN:   cfg_sig_en_q   <= cfg_data_i[0];
        default:      cfg_sig_en_q   <= cfg_sig_en_q;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      data_q <= data_in_i;
      lep_q  <= local_endpoint_i;
      lidx_q <= local_index_i;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= AddrW'(clr_cnt_q + 1'b1);
    end
  end

  assign stat_o.clr_last = (clr_cnt_q == AddrW'(StoreDepth - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign sel_ep = data_q[3:0] & EpMask[3:0];
  assign sel_ok = (sel_ep < cfg_ep_count_q) && (32'(sel_ep) < MaxEndpoints);
  assign idx_ok = flag_q && (SizeW'(idx_q) < ep_size(cfg_ep_sizes_q, sel_q));

  always_comb begin
    mode_d     = mode_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    sel_d      = sel_q;
    flag_d     = flag_q;
    resp_d     = R_NONE;
    rdata_d    = '0;
    sv_d       = 1'b0;
    sep_d      = '0;
    scode_d    = '0;
    item_we    = 1'b0;
    item_waddr = store_addr(sel_q, idx_q);
    unique case (func_q)
      FN_ADDR: begin
        if (cfg_sig_en_q && (mode_q == M_SIGNAL)) begin
          resp_d = R_NACK;
        end else begin
          resp_d = R_ACK;
          mode_d = M_SELECT;
        end
      end
      FN_STOP: begin
        resp_d = R_DONE;
        mode_d = ((cmd_q & SigMask) != 8'd0) ? M_SIGNAL : M_IDLE;
      end
      FN_WRITE: begin
        unique case (mode_q)
          M_SELECT: begin
            cmd_d = data_q;
            idx_d = '0;
            if (sel_ok) begin
              sel_d  = sel_ep[EpW-1:0];
              flag_d = 1'b1;
              resp_d = R_ACK;
              mode_d = M_SETIDX;
            end else begin
              resp_d = R_NACK;
              mode_d = M_ERROR;
            end
          end
          M_SETIDX: begin
            idx_d  = data_q;
            resp_d = R_ACK;
            mode_d = M_RW;
          end
          M_RW: begin
            if (idx_ok && cfg_wr_mask_q[sel_q]) begin
              item_we = 1'b1;
              idx_d   = IdxW'(idx_q + 1'b1);
              resp_d  = R_ACK;
            end else begin
              resp_d = R_NACK;
              mode_d = M_ERROR;
            end
          end
          default: begin
            resp_d = R_NACK;
          end
        endcase
      end
      FN_READ: begin
        if (!idx_ok) begin
          resp_d = R_DONE;
          mode_d = M_IDLE;
        end else begin
          rdata_d = st_rdata;
          idx_d   = IdxW'(idx_q + 1'b1);
          resp_d  = R_ACK;
        end
      end
      FN_TICK: begin
        if (cfg_sig_en_q && (mode_q == M_SIGNAL)) begin
          cmd_d = cmd_q & ~SigMask;
          if (flag_q) begin
            sv_d    = 1'b1;
            sep_d   = sel_q;
            scode_d = 3'((cmd_q & SigMask) >> SigShift);
          end
          mode_d = M_IDLE;
        end
      end
      FN_LOCAL: begin
        if ((32'(lep_q) < MaxEndpoints) && (32'(lidx_q) < EndpointBytes)) begin
          item_we    = 1'b1;
          item_waddr = store_addr(lep_q, lidx_q);
        end
      end
      default: begin
        resp_d = R_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cmd_q  <= '0;
      idx_q  <= '0;
      sel_q  <= '0;
      flag_q <= 1'b0;
    end else if (cmd_i.commit) begin
      mode_q <= mode_d;
      cmd_q  <= cmd_d;
      idx_q  <= idx_d;
      sel_q  <= sel_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      resp_q  <= resp_d;
      rdata_q <= rdata_d;
      sv_q    <= sv_d;
      sep_q   <= sep_d;
      scode_q <= scode_d;
    end
  end

  assign st_we    = cmd_i.clr_step || (cmd_i.commit && item_we);
  assign st_waddr = cmd_i.clr_step ? clr_cnt_q : item_waddr;
  assign st_wdata = cmd_i.clr_step ? 8'd0 : data_q;

  i2c_trf_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (store_addr(sel_q, idx_q)),
    .rdata_o (st_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign response_o        = resp_q;
  assign read_data_o       = rdata_q;
  assign signal_valid_o    = sv_q;
  assign signal_endpoint_o = sep_q;
  assign signal_code_o     = scode_q;

endmodule

// File: rtl/core/i2c_target_register_file_port_top.sv
// i2c target register file port: byte-level back end of an i2c target
// result: registered once the output is free, after its item is captured
// one item at a time: the next is taken only after the last is committed
// reset: a clearing pass zeroes all 2048 store entries; no item is taken
// meanwhile, configuration writes are. depends on i2c_trf_pkg, ctrl, dp
`include "i2c_target_register_file_port_top_defines.svh"
module i2c_target_register_file_port_top
  import i2c_trf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_in_i,
  input  logic [2:0]  local_endpoint_i,
  input  logic [7:0]  local_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  response_o,
  output logic [7:0]  read_data_o,
  output logic        signal_valid_o,
  output logic [2:0]  signal_endpoint_o,
  output logic [2:0]  signal_code_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  assign cfg_ready_o = 1'b1;

  i2c_trf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd),
    .in_ready_o (in_ready_o)
  );

  i2c_trf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .stat_o            (dp_stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .func_i            (func_i),
    .data_in_i         (data_in_i),
    .local_endpoint_i  (local_endpoint_i),
    .local_index_i     (local_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .response_o        (response_o),
    .read_data_o       (read_data_o),
    .signal_valid_o    (signal_valid_o),
    .signal_endpoint_o (signal_endpoint_o),
    .signal_code_o     (signal_code_o)
  );

  `TRF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `TRF_ASSERT_IMP(a_signal_no_resp, clk_i, rst_ni, out_valid_o && signal_valid_o, response_o == R_NONE)
  `TRF_ASSERT_IMP(a_rdata_only_ack, clk_i, rst_ni, out_valid_o && (response_o != R_ACK), read_data_o == 8'd0)

endmodule

// File: tb/sv/tb_i2c_trf_reply_pkg.sv
// reply scoreboard for the i2c target register file port testbench
// predicts each reply from the accepted bus events; depends on i2c_trf_pkg
package tb_i2c_trf_reply_pkg;
  import i2c_trf_pkg::*;

  typedef struct packed {
    logic [1:0] response;
    logic [7:0] read_data;
    logic       signal_valid;
    logic [2:0] signal_endpoint;
    logic [2:0] signal_code;
  } reply_t;

  class i2c_reply_scoreboard;
    logic [3:0]  ep_count;
    logic [63:0] ep_sizes;
    logic [7:0]  wr_mask;
    logic        sig_en;
    mode_e       bus_state;
    logic [7:0]  cmd_byte;
    logic [7:0]  byte_ptr;
    logic [2:0]  cur_ep;
    logic        ep_chosen;
    logic [7:0]  regs [StoreDepth];
    reply_t      expected_replies [$];
    int unsigned errors;

    function new();
      ep_count  = 4'd1;
      ep_sizes  = 64'd8;
      wr_mask   = 8'h00;
      sig_en    = 1'b1;
      bus_state = M_IDLE;
      cmd_byte  = 8'h00;
      byte_ptr  = 8'h00;
      cur_ep    = 3'd0;
      ep_chosen = 1'b0;
      errors    = 0;
      foreach (regs[i]) regs[i] = 8'h00;
    endfunction

    function void write_register(cfg_idx_e idx, logic [63:0] value);
      case (idx)
        CFG_EP_COUNT: ep_count = value[3:0];
        CFG_EP_SIZES: ep_sizes = value;
        CFG_WR_MASK:  wr_mask  = value[7:0];
        CFG_SIG_EN:   sig_en   = value[0];
      endcase
    endfunction

    function int unsigned size_of(logic [2:0] ep);
      int unsigned s;
      s = int'(ep_sizes[8*ep +: 8]);
      if (s > EndpointBytes) s = EndpointBytes;
      return s;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // advance the port state by one bus event and queue the reply it gives
    function void take_event(logic [2:0] fn, logic [7:0] data, logic [2:0] lep,
                             logic [7:0] lidx);
      reply_t     r;
      logic [3:0] ep;
      r = '0;
      r.response = R_NONE;
      case (fn)
        FN_ADDR: begin
          if (sig_en && bus_state == M_SIGNAL) begin
            r.response = R_NACK;
          end else begin
            r.response = R_ACK;
            bus_state = M_SELECT;
          end
        end
        FN_STOP: begin
          r.response = R_DONE;
          bus_state = ((cmd_byte & SigMask) != 8'h00) ? M_SIGNAL : M_IDLE;
        end
        FN_WRITE: begin
          case (bus_state)
            M_SELECT: begin
              ep = data[3:0];
              cmd_byte = data;
              if (ep < ep_count && ep < MaxEndpoints) begin
                cur_ep = ep[2:0];
                ep_chosen = 1'b1;
                r.response = R_ACK;
                bus_state = M_SETIDX;
              end else begin
                r.response = R_NACK;
                bus_state = M_ERROR;
              end
              byte_ptr = 8'h00;
            end
            M_SETIDX: begin
              byte_ptr = data;
              r.response = R_ACK;
              bus_state = M_RW;
            end
            M_RW: begin
              if (ep_chosen && byte_ptr < size_of(cur_ep) && wr_mask[cur_ep]) begin
                regs[{cur_ep, byte_ptr}] = data;
                byte_ptr = byte_ptr + 8'd1;
                r.response = R_ACK;
              end else begin
                r.response = R_NACK;
                bus_state = M_ERROR;
              end
            end
            default: r.response = R_NACK;
          endcase
        end
        FN_READ: begin
          if (!ep_chosen || byte_ptr >= size_of(cur_ep)) begin
            r.response = R_DONE;
            bus_state = M_IDLE;
          end else begin
            r.read_data = regs[{cur_ep, byte_ptr}];
            byte_ptr = byte_ptr + 8'd1;
            r.response = R_ACK;
          end
        end
        FN_TICK: begin
          if (sig_en && bus_state == M_SIGNAL) begin
            if (ep_chosen) begin
              r.signal_valid = 1'b1;
              r.signal_endpoint = cur_ep;
              r.signal_code = cmd_byte[7:5];
            end
            cmd_byte = cmd_byte & ~SigMask;
            bus_state = M_IDLE;
          end
        end
        FN_LOCAL: regs[{lep, lidx}] = data;
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with no transaction outstanding");
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      compare("response", 8'(want.response), 8'(got.response));
      compare("read_data", want.read_data, got.read_data);
      compare("signal_valid", 8'(want.signal_valid), 8'(got.signal_valid));
      compare("signal_endpoint", 8'(want.signal_endpoint), 8'(got.signal_endpoint));
      compare("signal_code", 8'(want.signal_code), 8'(got.signal_code));
    endfunction
  endclass

endpackage

// File: tb/sv/tb_i2c_target_register_file_port_top.sv
// testbench top for the i2c target register file port
// drives bus events, register writes and random stalls; checks every reply
// depends on i2c_trf_pkg, tb_i2c_trf_reply_pkg and the rtl top
module tb_i2c_target_register_file_port_top;
  import i2c_trf_pkg::*;
  import tb_i2c_trf_reply_pkg::*;

  localparam int unsigned LongStall  = 150;
  localparam int unsigned LimitTicks = 20 * 400_000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [63:0] cfg_data_i = 64'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = 3'd0;
  logic [7:0]  data_in_i = 8'd0;
  logic [2:0]  local_endpoint_i = 3'd0;
  logic [7:0]  local_index_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  response_o;
  logic [7:0]  read_data_o;
  logic        signal_valid_o;
  logic [2:0]  signal_endpoint_o;
  logic [2:0]  signal_code_o;

  int unsigned tx_idle_pct = 34;
  int unsigned rx_idle_pct = 57;
  int unsigned stall_req   = 0;
  int unsigned stall_done  = 0;
  int unsigned items_sent  = 0;

  i2c_reply_scoreboard reply_sb = new();

  i2c_target_register_file_port_top DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(LimitTicks);
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      reply_sb.write_register(cfg_idx_e'(cfg_index_i), cfg_data_i);
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      reply_sb.take_event(func_i, data_in_i, local_endpoint_i, local_index_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      reply_sb.check_reply('{response_o, read_data_o, signal_valid_o,
                             signal_endpoint_o, signal_code_o});
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_done != stall_req) begin
        stall_done++;
        out_ready_i <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(input logic [3:0] count, input logic [63:0] sizes,
                            input logic [7:0] wmask, input logic sen);
    write_reg(CFG_EP_COUNT, 64'(count));
    write_reg(CFG_EP_SIZES, sizes);
    write_reg(CFG_WR_MASK, 64'(wmask));
    write_reg(CFG_SIG_EN, 64'(sen));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input logic [2:0] fn, input logic [7:0] data,
                           input logic [2:0] lep, input logic [7:0] lidx);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 3);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= fn;
    data_in_i        <= data;
    local_endpoint_i <= lep;
    local_index_i    <= lidx;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (reply_sb.pending() != 0);
  endtask

  function automatic logic [63:0] random_sizes();
    logic [63:0] v;
    for (int k = 0; k < 8; k++) begin
      v[8*k +: 8] = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(16));
    end
    return v;
  endfunction

  // mostly a selectable endpoint, sometimes any code the low nibble allows
  function automatic logic [7:0] pick_command();
    int unsigned lim;
    logic [3:0]  ep;
    lim = (reply_sb.ep_count > MaxEndpoints) ? MaxEndpoints : int'(reply_sb.ep_count);
    if (lim == 0 || $urandom_range(6) == 0) ep = 4'($urandom);
    else ep = 4'($urandom_range(lim - 1));
    return {(($urandom_range(1) != 0) ? 3'($urandom) : 3'd0), 1'($urandom), ep};
  endfunction

  function automatic logic [7:0] pick_index(input logic [3:0] ep);
    int unsigned s;
    s = reply_sb.size_of(ep[2:0]);
    case ($urandom_range(9))
      0: return 8'($urandom);
      1: return 8'(s + 1 - $urandom_range(2));
      default: return (s == 0) ? 8'd0 : 8'($urandom_range(s - 1));
    endcase
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    logic [7:0]  cmd;
    logic [7:0]  ptr;
    logic [2:0]  lep;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) begin
        // write or read transaction with random content
        cmd = pick_command();
        send_item(FN_ADDR, 8'($urandom), 3'($urandom), 8'($urandom));
        send_item(FN_WRITE, cmd, 3'($urandom), 8'($urandom));
        send_item(FN_WRITE, pick_index(cmd[3:0]), 3'($urandom), 8'($urandom));
        if (r < 28) begin
          repeat ($urandom_range(6)) begin
            send_item(FN_WRITE, 8'($urandom), 3'($urandom), 8'($urandom));
          end
        end else begin
          send_item(FN_ADDR, 8'($urandom), 3'($urandom), 8'($urandom));
          repeat ($urandom_range(1, 8)) begin
            send_item(FN_READ, 8'($urandom), 3'($urandom), 8'($urandom));
          end
        end
        send_item(FN_STOP, 8'($urandom), 3'($urandom), 8'($urandom));
        if (cmd[7:5] != 3'd0 && $urandom_range(3) != 0) begin
          send_item(FN_TICK, 8'($urandom), 3'($urandom), 8'($urandom));
        end
      end else if (r < 72) begin
        lep = 3'($urandom);
        ptr = ($urandom_range(1) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
        repeat ($urandom_range(1, 6)) begin
          send_item(FN_LOCAL, 8'($urandom), lep, ptr);
          ptr = ptr + 8'd1;
        end
      end else if (r < 80) begin
        send_item(FN_TICK, 8'($urandom), 3'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(3'($urandom), 8'($urandom), 3'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(4'd8, 64'hFF04_1008_0020_0201, 8'hBF, 1'b1);
    // read and write before any endpoint is selected
    send_item(FN_READ, 8'h00, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'h00, 3'd0, 8'h00);
    send_item(FN_LOCAL, 8'hFF, 3'd7, 8'hFF);
    send_item(FN_LOCAL, 8'h00, 3'd0, 8'h00);
    // bad select, then a pending signal with nothing ever selected
    send_item(FN_ADDR, 8'h00, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'hEF, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'h12, 3'd0, 8'h00);
    send_item(FN_STOP, 8'h00, 3'd0, 8'h00);
    send_item(FN_ADDR, 8'h00, 3'd0, 8'h00);
    send_item(FN_TICK, 8'h00, 3'd0, 8'h00);
    // write up to the end of endpoint 7
    send_item(FN_ADDR, 8'h00, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'hA7, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'hFE, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'h80, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'h01, 3'd0, 8'h00);
    // read back across the end, then dispatch the signal
    send_item(FN_ADDR, 8'h00, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'hA7, 3'd0, 8'h00);
    send_item(FN_WRITE, 8'hFE, 3'd0, 8'h00);
    send_item(FN_ADDR, 8'h00, 3'd0, 8'h00);
    send_item(FN_READ, 8'h00, 3'd0, 8'h00);
    send_item(FN_READ, 8'h00, 3'd0, 8'h00);
    send_item(FN_STOP, 8'h00, 3'd0, 8'h00);
    send_item(FN_TICK, 8'h00, 3'd0, 8'h00);
    send_item(3'd6, 8'h55, 3'd2, 8'h33);
    send_item(3'd7, 8'hAA, 3'd5, 8'hCC);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(4'd8, random_sizes(), 8'hFF, 1'b1);
        1: set_config(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'($urandom), 1'b0);
        2: set_config(4'd0, 64'd0, 8'h00, 1'b1);
        3: set_config(4'($urandom_range(1, 8)), random_sizes(), 8'($urandom), 1'b1);
        4: set_config(4'd8, random_sizes(), 8'($urandom), 1'($urandom));
        default: set_config(4'($urandom), random_sizes(), 8'($urandom), 1'($urandom));
      endcase
      case (ph / 2)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 0 || ph == 4) stall_req++;
      run_random((ph == 2) ? 30 : 95);
      in_valid_i <= 1'b0;
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (reply_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
